// ===== hw/rtl/ts_packet_sync_and_parse_defines.svh =====
// assertion macros for the transport stream sync and parse block
`ifndef TS_PACKET_SYNC_AND_PARSE_DEFINES_SVH
`define TS_PACKET_SYNC_AND_PARSE_DEFINES_SVH

// invariant checked on every rising clock edge out of reset
`define TSPS_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tsps invariant violated");

// same-cycle implication
`define TSPS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsps implication violated");

// next-cycle implication
`define TSPS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsps sequence violated");

`endif

// ===== hw/rtl/tsps_pkg.sv =====
// shared constants and types of the transport stream sync and parse block
`default_nettype none
package tsps_pkg;
	localparam int PACKET_BYTES = 188;
	localparam int HEADER_BYTES = 4;
	localparam int IV_W = 9;
	localparam int CFG_AW = 3;
	localparam logic [7:0] SYNC_MARK = 8'h47;
	localparam logic [IV_W-1:0] MIN_INTERVAL = 9'd188;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [12:0] packet_id;
		logic        transport_error;
		logic        unit_start;
		logic        priority_bit;
		logic [1:0]  scrambling;
		logic [1:0]  adaptation_control;
		logic [3:0]  continuity;
		logic [7:0]  payload_length;
		logic        first_in_packet;
		logic        last_in_packet;
		logic        resynced;
	} result_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tsps_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none
module tsps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/tsps_cfg.sv =====
// apb register file holding the packet interval
`default_nettype none
module tsps_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tsps_pkg::CFG_AW-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output logic      [tsps_pkg::IV_W-1:0]   iv_live
);
	import tsps_pkg::*;

	localparam logic REG_INTERVAL = 1'b0;

	logic [IV_W-1:0] iv_q;
	logic            word;
	logic            wr;

	assign word   = paddr[CFG_AW-1];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_q <= MIN_INTERVAL;
		end else if (wr && word == REG_INTERVAL) begin
			iv_q <= pwdata[IV_W-1:0];
		end
	end

	always_comb begin
		unique case (word)
			REG_INTERVAL: prdata = {{(32-IV_W){1'b0}}, iv_q};
			default:      prdata = '0;
		endcase
	end

	// intervals below the standard packet size act as the standard size
	assign iv_live = (iv_q < MIN_INTERVAL) ? MIN_INTERVAL : iv_q;
endmodule
`default_nettype wire

// ===== hw/rtl/tsps_out.sv =====
// output holding register for result transactions
`default_nettype none
module tsps_out (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire tsps_pkg::result_t res,
	input  wire logic              stall,
	output logic                   valid,
	output tsps_pkg::result_t      res_q,
	output logic                   free
);
	import tsps_pkg::*;

	logic valid_q;

	assign valid = valid_q;
	assign free  = !valid_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ts_packet_sync_and_parse.sv =====
// top level of the transport stream packet sync and parse block
// Transport stream sync and parse. Raw stream bytes enter on the input channel and are
// written into a circular lookahead window RAM of WINDOW_BYTES bytes. Packets repeat every
// packet_interval bytes (register 0, values below 188 act as 188). At each expected packet
// start the block checks that byte and the one an interval later; only when both miss the
// 0x47 sync value does it search forward, one candidate per input byte, for a 0x47 followed
// by LOCK_REPEATS more at interval spacing. The 4-byte header is decoded, an adaptation
// field is skipped when present, and each payload byte up to packet byte 187 leaves as one
// output transaction carrying the header fields. Every input byte triggers at most one
// window action, and all window reads go through the single read port of the RAM, one
// address per cycle, with registered read data. The block takes no new input byte until
// the action of the last one is done, including any wait on a stalled result. There is
// no clearing pass after reset: window entries are read only after they have been written.
`default_nettype none
`include "ts_packet_sync_and_parse_defines.svh"
module ts_packet_sync_and_parse #(
	parameter int WINDOW_BYTES = 4096,
	parameter int LOCK_REPEATS = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// input byte channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [7:0]                  stream_byte,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [7:0]                  payload_byte,
	output logic      [12:0]                 packet_id,
	output logic                             transport_error,
	output logic                             unit_start,
	output logic                             priority_bit,
	output logic      [1:0]                  scrambling,
	output logic      [1:0]                  adaptation_control,
	output logic      [3:0]                  continuity,
	output logic      [7:0]                  payload_length,
	output logic                             first_in_packet,
	output logic                             last_in_packet,
	output logic                             resynced,
	// configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tsps_pkg::CFG_AW-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);
	import tsps_pkg::*;

	localparam int AW = $clog2(WINDOW_BYTES);
	localparam int FW = $clog2(WINDOW_BYTES + 1);
	localparam int CW = (FW > 14) ? FW : 14;
	localparam int IW = ($clog2(LOCK_REPEATS + 1) > 3) ? $clog2(LOCK_REPEATS + 1) : 3;
	localparam logic [AW:0]   WIN_A  = (AW+1)'(WINDOW_BYTES);
	localparam logic [FW-1:0] WIN_F  = FW'(WINDOW_BYTES);
	localparam logic [IW-1:0] LOCK_I = IW'(LOCK_REPEATS);
	localparam logic [CW-1:0] LOCK_C = CW'(LOCK_REPEATS);

	// parse phase kept across input bytes
	typedef enum logic [3:0] {
		PH_WAIT    = 4'b0001,
		PH_SEARCH  = 4'b0010,
		PH_HEADER  = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} ph_t;

	// per-byte sequencer
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DECIDE = 4'b0010,
		ST_READ   = 4'b0100,
		ST_EMIT   = 4'b1000
	} st_t;

	// circular add of a short offset to a window address
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
		input logic [IV_W-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + (AW+1)'(b);
		if (s >= WIN_A) begin
			s = s - WIN_A;
		end
		return s[AW-1:0];
	endfunction

	st_t             st_q;
	ph_t             phase_q;
	logic [AW-1:0]   wp_q;      // write position
	logic [AW-1:0]   ps_q;      // packet start
	logic [AW-1:0]   sp_q;      // search candidate
	logic [FW-1:0]   fill_q;    // bytes held from the read anchor
	logic [31:0]     hdr_q;
	logic [8:0]      off_q;     // payload offset inside the packet
	logic [IV_W-1:0] held_iv_q;
	logic [7:0]      held_len_q;
	logic            held_rs_q;
	logic [AW-1:0]   addr_q;    // next window read address
	logic [IV_W-1:0] step_q;    // address stride of the read burst
	logic [IW-1:0]   idx_q;     // index of the read data now returning
	logic            nosync_q;  // expected start byte missed sync
	logic [7:0]      byte_q;

	logic [IV_W-1:0] iv;
	logic            accept;
	logic            ovf;
	logic [AW-1:0]   first_addr;
	logic [IV_W-1:0] step;
	logic [AW-1:0]   raddr;
	logic [7:0]      rdata;
	logic            ge_wait;
	logic            ge_search;
	logic [8:0]      off_calc;
	logic            off_short;
	logic [AW-1:0]   np_ps;
	logic [FW-1:0]   np_fill;
	logic            last;
	logic            out_free;
	logic            emit;
	result_t         res;
	result_t         res_q;

	tsps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.iv_live (iv)
	);

	// lookahead window: written on every accepted byte, read by the sequencer
	tsps_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_BYTES)
	) u_window (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (stream_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign in_stall = (st_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign ovf      = (fill_q >= WIN_F);

	// first read of the burst and its stride, by phase
	always_comb begin
		unique case (phase_q) inside
			PH_SEARCH: begin
				first_addr = sp_q;
				step       = iv;
			end
			PH_HEADER: begin
				first_addr = ps_q;
				step       = IV_W'(1);
			end
			PH_PAYLOAD: begin
				first_addr = wrap_add(ps_q, off_q);
				step       = IV_W'(1);
			end
			default: begin
				first_addr = ps_q;
				step       = iv;
			end
		endcase
	end

	assign raddr = (st_q == ST_DECIDE) ? first_addr : addr_q;

	// enough bytes present for the sync check or for a full search candidate
	assign ge_wait   = CW'(fill_q) >= CW'(iv) + CW'(1);
	assign ge_search = CW'(fill_q) >= CW'(iv) * LOCK_C + CW'(1);

	// payload start: header, plus length byte and adaptation field when present
	assign off_calc  = hdr_q[5] ? 9'(HEADER_BYTES) + 9'd1 + {1'b0, rdata}
		: 9'(HEADER_BYTES);
	assign off_short = (off_calc >= 9'(PACKET_BYTES));

	// step to the next packet
	assign np_ps   = wrap_add(ps_q, held_iv_q);
	assign np_fill = (fill_q >= FW'(held_iv_q)) ? fill_q - FW'(held_iv_q) : '0;

	assign last = (off_q >= 9'(PACKET_BYTES - 1));
	assign emit = (st_q == ST_EMIT) && out_free;

	always_comb begin
		res.payload_byte       = byte_q;
		res.packet_id          = {hdr_q[20:16], hdr_q[15:8]};
		res.transport_error    = hdr_q[23];
		res.unit_start         = hdr_q[22];
		res.priority_bit       = hdr_q[21];
		res.scrambling         = hdr_q[7:6];
		res.adaptation_control = hdr_q[5:4];
		res.continuity         = hdr_q[3:0];
		res.payload_length     = held_len_q;
		res.first_in_packet    = (off_q == 9'(PACKET_BYTES) - {1'b0, held_len_q});
		res.last_in_packet     = last;
		res.resynced           = held_rs_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			phase_q    <= PH_WAIT;
			wp_q       <= '0;
			ps_q       <= '0;
			sp_q       <= '0;
			fill_q     <= '0;
			hdr_q      <= '0;
			off_q      <= '0;
			held_iv_q  <= MIN_INTERVAL;
			held_len_q <= '0;
			held_rs_q  <= 1'b0;
			addr_q     <= '0;
			step_q     <= '0;
			idx_q      <= '0;
			nosync_q   <= 1'b0;
			byte_q     <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						wp_q <= wrap_add(wp_q, IV_W'(1));
						if (ovf) begin
							// window full: drop the oldest byte and hunt again from there
							sp_q    <= wrap_add((phase_q == PH_SEARCH) ? sp_q : ps_q, IV_W'(1));
							fill_q  <= WIN_F;
							phase_q <= PH_SEARCH;
						end else begin
							fill_q <= fill_q + FW'(1);
						end
						st_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					addr_q <= wrap_add(first_addr, step);
					step_q <= step;
					idx_q  <= '0;
					unique case (phase_q) inside
						PH_SEARCH: begin
							st_q <= ge_search ? ST_READ : ST_IDLE;
						end
						PH_HEADER, PH_PAYLOAD: begin
							st_q <= ST_READ;
						end
						default: begin
							phase_q <= PH_WAIT;
							st_q    <= ge_wait ? ST_READ : ST_IDLE;
						end
					endcase
				end
				ST_READ: begin
					addr_q <= wrap_add(addr_q, step_q);
					idx_q  <= idx_q + IW'(1);
					unique case (phase_q) inside
						PH_SEARCH: begin
							if (rdata != SYNC_MARK) begin
								// candidate failed, try the next byte on the next input
								sp_q   <= wrap_add(sp_q, IV_W'(1));
								fill_q <= fill_q - FW'(1);
								st_q   <= ST_IDLE;
							end else if (idx_q == LOCK_I) begin
								ps_q      <= sp_q;
								held_iv_q <= iv;
								held_rs_q <= 1'b1;
								phase_q   <= PH_HEADER;
								st_q      <= ST_IDLE;
							end
						end
						PH_HEADER: begin
							if (idx_q < IW'(HEADER_BYTES)) begin
								hdr_q <= {hdr_q[23:0], rdata};
							end else begin
								if (off_short) begin
									// adaptation field covers the whole packet
									held_len_q <= '0;
									ps_q       <= np_ps;
									fill_q     <= np_fill;
									phase_q    <= PH_WAIT;
								end else begin
									off_q      <= off_calc;
									held_len_q <= 8'(9'(PACKET_BYTES) - off_calc);
									phase_q    <= PH_PAYLOAD;
								end
								st_q <= ST_IDLE;
							end
						end
						PH_PAYLOAD: begin
							byte_q <= rdata;
							st_q   <= ST_EMIT;
						end
						default: begin
							if (idx_q == '0) begin
								nosync_q <= (rdata != SYNC_MARK);
							end else begin
								if (nosync_q && rdata != SYNC_MARK) begin
									sp_q    <= ps_q;
									phase_q <= PH_SEARCH;
								end else begin
									held_iv_q <= iv;
									held_rs_q <= 1'b0;
									phase_q   <= PH_HEADER;
								end
								st_q <= ST_IDLE;
							end
						end
					endcase
				end
				ST_EMIT: begin
					if (out_free) begin
						if (last) begin
							ps_q    <= np_ps;
							fill_q  <= np_fill;
							phase_q <= PH_WAIT;
						end else begin
							off_q <= off_q + 9'd1;
						end
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	tsps_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit),
		.res    (res),
		.stall  (out_stall),
		.valid  (out_valid),
		.res_q  (res_q),
		.free   (out_free)
	);

	assign payload_byte       = res_q.payload_byte;
	assign packet_id          = res_q.packet_id;
	assign transport_error    = res_q.transport_error;
	assign unit_start         = res_q.unit_start;
	assign priority_bit       = res_q.priority_bit;
	assign scrambling         = res_q.scrambling;
	assign adaptation_control = res_q.adaptation_control;
	assign continuity         = res_q.continuity;
	assign payload_length     = res_q.payload_length;
	assign first_in_packet    = res_q.first_in_packet;
	assign last_in_packet     = res_q.last_in_packet;
	assign resynced           = res_q.resynced;

	// an accepted byte always starts a window action decision
	`TSPS_ASSERT_NXT(a_accept_decide, accept, st_q == ST_DECIDE)
	// held byte count never exceeds the window
	`TSPS_ASSERT(a_fill_bound, fill_q <= WIN_F)
	// results only come from payload parsing inside the packet
	`TSPS_ASSERT_IMP(a_emit_payload, emit, phase_q == PH_PAYLOAD && off_q < 9'(PACKET_BYTES))
endmodule
`default_nettype wire

// ===== verif/ts_packet_sync_and_parse_test.sv =====
// testbench for the transport stream sync and parse block: random framed streams against a predictor
`default_nettype none
module ts_packet_sync_and_parse_test;
	import tsps_pkg::*;

	localparam int WIN = 4096;
	localparam int LOCKS = 8;
	localparam logic [CFG_AW-1:0] ADDR_PACKET_INTERVAL = 3'd0;
	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD = 600;

	typedef enum int {PH_WAIT, PH_SEARCH, PH_HEADER, PH_PAYLOAD} parse_phase_e;

	// scoreboard: mirrors the parser state and keeps the payload bytes still owed
	class payload_scoreboard;
		logic [7:0] win_mem [WIN];
		int unsigned wr_pos, pkt_start, srch_pos, pay_off, held_bytes;
		int unsigned iv_reg, lat_iv, lat_len, lat_resync;
		logic [31:0] hdr;
		parse_phase_e phase;
		result_t owed_q[$];
		int errors, results_seen;

		function new();
			wr_pos = 0; pkt_start = 0; srch_pos = 0; pay_off = 0; held_bytes = 0;
			iv_reg = 188; lat_iv = 188; lat_len = 0; lat_resync = 0;
			hdr = '0; phase = PH_WAIT; errors = 0; results_seen = 0;
			foreach (win_mem[i]) win_mem[i] = '0;
		endfunction

		function void report(string what);
			errors++;
			if (errors <= 30) $display("mismatch: %s", what);
		endfunction

		function int unsigned at(int unsigned base, int unsigned off);
			return win_mem[(base + off) % WIN];
		endfunction

		function int unsigned live_iv();
			return (iv_reg < 188) ? 188 : iv_reg;
		endfunction

		function bit sync_run(int unsigned pos, int unsigned iv);
			if (at(pos, 0) != SYNC_MARK) return 0;
			for (int k = 1; k <= LOCKS; k++)
				if (at(pos, iv * k) != SYNC_MARK) return 0;
			return 1;
		endfunction

		function void next_packet();
			pkt_start = (pkt_start + lat_iv) % WIN;
			held_bytes = (held_bytes >= lat_iv) ? held_bytes - lat_iv : 0;
			phase = PH_WAIT;
		endfunction

		// one accepted stream byte: store it, take one parse action
		function void note_byte(logic [7:0] b);
			int unsigned iv, off;
			logic [7:0] b1, b3;
			result_t r;
			if (held_bytes >= WIN) begin
				srch_pos = ((phase == PH_SEARCH) ? srch_pos : pkt_start) + 1;
				srch_pos = srch_pos % WIN;
				held_bytes = WIN - 1;
				phase = PH_SEARCH;
			end
			win_mem[wr_pos] = b;
			wr_pos = (wr_pos + 1) % WIN;
			held_bytes++;
			case (phase)
				PH_SEARCH: begin
					iv = live_iv();
					if (held_bytes >= iv * LOCKS + 1) begin
						if (sync_run(srch_pos, iv)) begin
							pkt_start = srch_pos; lat_iv = iv; lat_resync = 1; phase = PH_HEADER;
						end else begin
							srch_pos = (srch_pos + 1) % WIN;
							held_bytes--;
						end
					end
				end
				PH_HEADER: begin
					hdr = {8'(at(pkt_start, 0)), 8'(at(pkt_start, 1)),
						8'(at(pkt_start, 2)), 8'(at(pkt_start, 3))};
					off = HEADER_BYTES;
					if (hdr[5]) off += 1 + at(pkt_start, HEADER_BYTES);
					if (off >= PACKET_BYTES) begin
						lat_len = 0;
						next_packet();
					end else begin
						pay_off = off;
						lat_len = PACKET_BYTES - off;
						phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					b1 = hdr[23:16];
					b3 = hdr[7:0];
					r.payload_byte = at(pkt_start, pay_off);
					r.packet_id = {b1[4:0], hdr[15:8]};
					r.transport_error = b1[7];
					r.unit_start = b1[6];
					r.priority_bit = b1[5];
					r.scrambling = b3[7:6];
					r.adaptation_control = b3[5:4];
					r.continuity = b3[3:0];
					r.payload_length = lat_len[7:0];
					r.first_in_packet = (pay_off == PACKET_BYTES - lat_len);
					r.last_in_packet = (pay_off + 1 >= PACKET_BYTES);
					r.resynced = lat_resync[0];
					owed_q.push_back(r);
					if (r.last_in_packet) next_packet();
					else pay_off++;
				end
				default: begin
					phase = PH_WAIT;
					iv = live_iv();
					if (held_bytes >= iv + 1) begin
						if (at(pkt_start, 0) != SYNC_MARK && at(pkt_start, iv) != SYNC_MARK) begin
							srch_pos = pkt_start;
							phase = PH_SEARCH;
						end else begin
							lat_iv = iv; lat_resync = 0; phase = PH_HEADER;
						end
					end
				end
			endcase
		endfunction

		function void field(string name, int unsigned got, int unsigned want);
			if (got != want)
				report($sformatf("result %0d %s got %0h expected %0h", results_seen, name, got, want));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (owed_q.size() == 0) begin
				report($sformatf("unexpected result %0d, byte %0h", results_seen, got.payload_byte));
			end else begin
				want = owed_q.pop_front();
				field("payload_byte", got.payload_byte, want.payload_byte);
				field("packet_id", got.packet_id, want.packet_id);
				field("transport_error", got.transport_error, want.transport_error);
				field("unit_start", got.unit_start, want.unit_start);
				field("priority_bit", got.priority_bit, want.priority_bit);
				field("scrambling", got.scrambling, want.scrambling);
				field("adaptation_control", got.adaptation_control, want.adaptation_control);
				field("continuity", got.continuity, want.continuity);
				field("payload_length", got.payload_length, want.payload_length);
				field("first_in_packet", got.first_in_packet, want.first_in_packet);
				field("last_in_packet", got.last_in_packet, want.last_in_packet);
				field("resynced", got.resynced, want.resynced);
			end
			results_seen++;
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall;
	logic [7:0] stream_byte;
	logic out_valid, out_stall;
	result_t res;
	logic psel, penable, pwrite, pready;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata, prdata;

	ts_packet_sync_and_parse dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .stream_byte(stream_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.payload_byte(res.payload_byte), .packet_id(res.packet_id),
		.transport_error(res.transport_error), .unit_start(res.unit_start),
		.priority_bit(res.priority_bit), .scrambling(res.scrambling),
		.adaptation_control(res.adaptation_control), .continuity(res.continuity),
		.payload_length(res.payload_length), .first_in_packet(res.first_in_packet),
		.last_in_packet(res.last_in_packet), .resynced(res.resynced),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	payload_scoreboard sb = new();
	logic [7:0] stream_q[$];    // bytes waiting to be offered
	bit quiet;                  // no idling on either side
	bit hold_req;               // ask the receiver for one long hold-off
	int bytes_sent, resync_pkts, empty_hdrs, quiet_cycles;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// result monitor, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (res.first_in_packet && res.resynced) resync_pkts++;
			sb.check_result(res);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results owed", sb.owed_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin : receiver
		int burst, hold;
		bit stalling;
		out_stall = 1'b0;
		burst = 0; hold = 0; stalling = 0;
		forever begin
			@(negedge clk);
			if (hold_req && hold == 0) begin
				hold = LONG_HOLD;
				hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				if (burst == 0) begin
					stalling = ($urandom_range(0, 3) == 0);
					burst = stalling ? $urandom_range(1, 18) : $urandom_range(1, 40);
				end
				burst--;
				out_stall <= stalling;
			end
		end
	end

	// offer every queued byte, with random gaps unless quiet
	task automatic send_stream();
		int gap;
		while (stream_q.size() > 0) begin
			gap = (!quiet && $urandom_range(0, 9) == 0) ? $urandom_range(1, 18) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			in_valid <= 1'b1;
			stream_byte <= stream_q.pop_front();
			do @(posedge clk); while (in_stall);
			sb.note_byte(stream_byte);
			bytes_sent++;
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// hold the stream until every owed result has arrived and the block has settled
	task automatic wait_drained();
		while (sb.owed_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_interval(int unsigned value);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= ADDR_PACKET_INTERVAL; pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.iv_reg = value & 9'h1ff;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// one framed packet of iv bytes; af_len < 0 picks a random adaptation length
	task automatic add_packet(int unsigned iv, logic [7:0] sync, logic [7:0] b1,
			logic [7:0] b2, logic [7:0] b3, int af_len);
		int unsigned afl;
		stream_q.push_back(sync);
		stream_q.push_back(b1);
		stream_q.push_back(b2);
		stream_q.push_back(b3);
		afl = (af_len >= 0) ? af_len :
			($urandom_range(0, 7) == 0) ? $urandom_range(178, 255) : $urandom_range(0, 40);
		if (b3[5] && afl + HEADER_BYTES + 1 >= PACKET_BYTES) empty_hdrs++;
		for (int unsigned i = HEADER_BYTES; i < iv; i++)
			stream_q.push_back((b3[5] && i == HEADER_BYTES) ? afl[7:0] : 8'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; stream_byte = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		quiet = 0; hold_req = 0;
		bytes_sent = 0; resync_pkts = 0; empty_hdrs = 0; quiet_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one-byte payload behind a long adaptation field, then a lost sync that is
		// ridden through because the byte one interval later is a sync
		add_packet(188, SYNC_MARK, 8'hbf, 8'h5a, 8'h30, 182);
		add_packet(188, 8'h00, 8'h1f, 8'hff, 8'hff, 0);
		stream_q.push_back(SYNC_MARK);
		repeat (4) stream_q.push_back(8'($urandom));
		send_stream();

		// receiver holds off long while the sender keeps offering payload bytes
		hold_req = 1;
		repeat (24) stream_q.push_back(8'($urandom));
		send_stream();
		wait_drained();

		// small register value acts as the standard interval
		write_interval(0);

		// last stretch without idling
		quiet = 1;
		repeat (20) stream_q.push_back(8'($urandom));
		send_stream();
		wait_drained();

		$display("sent %0d stream bytes, checked %0d payload bytes, %0d resynced packets",
			bytes_sent, sb.results_seen, resync_pkts);
		$display("covered a one-byte payload, a ridden-through lost sync, a long output hold-off");
		if (sb.errors == 0 && sb.owed_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.errors, sb.owed_q.size());
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tsps_pkg.sv
hw/rtl/tsps_ram.sv
hw/rtl/tsps_cfg.sv
hw/rtl/tsps_out.sv
hw/rtl/ts_packet_sync_and_parse.sv
verif/ts_packet_sync_and_parse_test.sv
